>>> src/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, ignored while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion on the rising clock edge that also holds through reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/urx7_pkg.sv
// Shared types, constants and the segment table of the UART receiver.
`timescale 1ns / 1ps

package urx7_pkg;

   localparam int DATA_BITS_DEF = 8;

   localparam int TICK_W  = 16;
   localparam int MODE_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int BYTE_W  = 8;
   localparam int SEG_W   = 7;

   localparam logic [TICK_W-1:0] TICKS_PER_BIT_RST = 16'd2604;

   localparam logic [MODE_W-1:0] PAR_NONE = 2'd0;
   localparam logic [MODE_W-1:0] PAR_EVEN = 2'd1;
   localparam logic [MODE_W-1:0] PAR_ODD  = 2'd2;

   localparam logic [MODE_W-1:0] PARITY_MODE_RST = PAR_EVEN;

   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_BIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PARITY_MODE   = 2'd1;

   // Active-low segments, one entry per hex digit.
   localparam logic [SEG_W-1:0] SEG_TABLE [0:15] = '{
      7'h01, 7'h4f, 7'h12, 7'h06, 7'h4c, 7'h24, 7'h20, 7'h0f,
      7'h00, 7'h04, 7'h08, 7'h60, 7'h31, 7'h42, 7'h30, 7'h38
   };

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_START  = 5'b00010,
      PH_DATA   = 5'b00100,
      PH_PARITY = 5'b01000,
      PH_STOP   = 5'b10000
   } rx_phase_type;

   typedef struct packed {
      logic [TICK_W-1:0] ticks_per_bit;
      logic [MODE_W-1:0] parity_mode;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              start_err;
      logic              parity_err;
      logic              stop_err;
   } frame_type;

endpackage

>>> src/uart_rx_parity_seven_segment.sv
// Top level of the oversampled UART receiver with seven-segment output.
`timescale 1ns / 1ps

// Each input word is one tick of the oversampling timer with the rx line
// level, and the block takes one word every clock cycle while req_stall is
// low. A low line while idle starts a frame; the start bit is sampled half a
// bit period later and the data bits (LSB first), the optional parity bit
// and the stop bit one period apart, the period being ticks_per_bit ticks.
// A frame's result word enters a two-entry queue in the cycle after the tick
// that samples the stop bit, so req_stall rises only when two finished words
// wait behind a stalled rsp side. The csr port accepts a write in every
// cycle; write it only while no frame is in flight.

module uart_rx_parity_seven_segment import urx7_pkg::*; #(
   parameter int DATA_BITS = DATA_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_rx_line,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BYTE_W-1:0]    rsp_data_byte,
   output logic [SEG_W-1:0]     rsp_seg_low_nibble,
   output logic [SEG_W-1:0]     rsp_seg_high_nibble,
   output logic                 rsp_start_error,
   output logic                 rsp_parity_error,
   output logic                 rsp_stop_error,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_wdata
);

   cfg_type   cfg;
   frame_type frame;
   logic      frame_push;
   logic      tick_accept;
   logic      queue_full;

   assign req_stall   = queue_full;
   assign tick_accept = req_valid && !req_stall;

   urx7_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   urx7_fsm #(
      .DATA_BITS (DATA_BITS)
   ) u_fsm (
      .clock       (clock),
      .reset       (reset),
      .tick_accept (tick_accept),
      .rx_line     (req_rx_line),
      .cfg         (cfg),
      .frame_push  (frame_push),
      .frame       (frame)
   );

   urx7_out u_out (
      .clock               (clock),
      .reset               (reset),
      .frame_push          (frame_push),
      .frame               (frame),
      .full                (queue_full),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_seg_low_nibble  (rsp_seg_low_nibble),
      .rsp_seg_high_nibble (rsp_seg_high_nibble),
      .rsp_start_error     (rsp_start_error),
      .rsp_parity_error    (rsp_parity_error),
      .rsp_stop_error      (rsp_stop_error)
   );

endmodule

>>> src/urx7_csr.sv
// Configuration registers: bit period and parity mode.
`timescale 1ns / 1ps

module urx7_csr import urx7_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TICKS_PER_BIT: cfg_in.ticks_per_bit = csr_wdata;
            CSR_PARITY_MODE:   cfg_in.parity_mode   = csr_wdata[MODE_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_bit <= TICKS_PER_BIT_RST;
         cfg_ff.parity_mode   <= PARITY_MODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> src/urx7_fsm.sv
// Frame state machine: bit timing, data shift, parity check and error flags.
`timescale 1ns / 1ps

module urx7_fsm import urx7_pkg::*; #(
   parameter int DATA_BITS = DATA_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      tick_accept,
   input  logic      rx_line,
   input  cfg_type   cfg,
   output logic      frame_push,
   output frame_type frame
);

   localparam int IDX_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;

   rx_phase_type         phase_ff, phase_in;
   logic [TICK_W-1:0]    tick_cnt_ff, tick_cnt_in;
   logic [IDX_W-1:0]     bit_idx_ff, bit_idx_in;
   logic [DATA_BITS-1:0] shift_ff, shift_in;
   logic                 par_acc_ff, par_acc_in;
   logic                 start_flag_ff, start_flag_in;
   logic                 par_flag_ff, par_flag_in;

   logic [TICK_W-1:0] half_period;
   logic [TICK_W-1:0] half_target;
   logic [TICK_W-1:0] full_target;
   logic [TICK_W-1:0] wait_target;
   logic [TICK_W-1:0] tick_inc;
   logic              wait_hit;
   logic [TICK_W-1:0] tick_after_wait;
   logic              parity_on;

   // A wait of zero ticks is stretched to one tick.
   assign half_period = cfg.ticks_per_bit >> 1;
   assign half_target = (half_period == '0) ? TICK_W'(1) : half_period;
   assign full_target = (cfg.ticks_per_bit == '0) ? TICK_W'(1) : cfg.ticks_per_bit;
   assign wait_target = (phase_ff == PH_START) ? half_target : full_target;
   assign tick_inc    = tick_cnt_ff + TICK_W'(1);
   // Compare with at least, so a shortened period during a frame cannot hang.
   assign wait_hit        = (tick_inc >= wait_target);
   assign tick_after_wait = wait_hit ? '0 : tick_inc;
   assign parity_on       = (cfg.parity_mode == PAR_EVEN) || (cfg.parity_mode == PAR_ODD);

   always_comb begin
      phase_in      = phase_ff;
      tick_cnt_in   = tick_cnt_ff;
      bit_idx_in    = bit_idx_ff;
      shift_in      = shift_ff;
      par_acc_in    = par_acc_ff;
      start_flag_in = start_flag_ff;
      par_flag_in   = par_flag_ff;
      frame_push    = 1'b0;
      if (tick_accept) begin
         case (phase_ff)
            PH_IDLE: begin
               if (!rx_line) begin
                  phase_in      = PH_START;
                  tick_cnt_in   = '0;
                  bit_idx_in    = '0;
                  shift_in      = '0;
                  par_acc_in    = 1'b0;
                  start_flag_in = 1'b0;
                  par_flag_in   = 1'b0;
               end
            end
            PH_START: begin
               tick_cnt_in = tick_after_wait;
               if (wait_hit) begin
                  start_flag_in = rx_line;
                  phase_in      = PH_DATA;
               end
            end
            PH_DATA: begin
               tick_cnt_in = tick_after_wait;
               if (wait_hit) begin
                  shift_in[bit_idx_ff] = rx_line;
                  par_acc_in           = par_acc_ff ^ rx_line;
                  bit_idx_in           = bit_idx_ff + IDX_W'(1);
                  if (bit_idx_ff == IDX_W'(DATA_BITS - 1)) begin
                     phase_in = parity_on ? PH_PARITY : PH_STOP;
                  end
               end
            end
            PH_PARITY: begin
               tick_cnt_in = tick_after_wait;
               if (wait_hit) begin
                  case (cfg.parity_mode)
                     PAR_EVEN: par_flag_in = (rx_line != par_acc_ff);
                     PAR_ODD:  par_flag_in = (rx_line == par_acc_ff);
                     default:  par_flag_in = 1'b0;
                  endcase
                  phase_in = PH_STOP;
               end
            end
            PH_STOP: begin
               tick_cnt_in = tick_after_wait;
               if (wait_hit) begin
                  frame_push  = 1'b1;
                  phase_in    = PH_IDLE;
                  tick_cnt_in = '0;
               end
            end
            default: begin
               phase_in    = PH_IDLE;
               tick_cnt_in = '0;
            end
         endcase
      end
   end

   assign frame.data_byte  = BYTE_W'(shift_ff);
   assign frame.start_err  = start_flag_ff;
   assign frame.parity_err = par_flag_ff;
   assign frame.stop_err   = !rx_line;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         tick_cnt_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         tick_cnt_ff <= tick_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_idx_ff    <= bit_idx_in;
      shift_ff      <= shift_in;
      par_acc_ff    <= par_acc_in;
      start_flag_ff <= start_flag_in;
      par_flag_ff   <= par_flag_in;
   end

endmodule

>>> src/urx7_out.sv
// Two-entry result queue with the seven-segment decode on its head.
`timescale 1ns / 1ps

module urx7_out import urx7_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              frame_push,
   input  frame_type         frame,
   output logic              full,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_data_byte,
   output logic [SEG_W-1:0]  rsp_seg_low_nibble,
   output logic [SEG_W-1:0]  rsp_seg_high_nibble,
   output logic              rsp_start_error,
   output logic              rsp_parity_error,
   output logic              rsp_stop_error
);

   frame_type head_ff, head_in;
   frame_type skid_ff, skid_in;
   logic      head_vld_ff, head_vld_in;
   logic      skid_vld_ff, skid_vld_in;
   logic      pop;

   assign pop = head_vld_ff && !rsp_stall;

   // The skid entry only fills while the head word is held, and the input
   // side stalls while it is occupied, so a push always finds a free slot.
   always_comb begin
      head_in     = head_ff;
      skid_in     = skid_ff;
      head_vld_in = head_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (pop) begin
         if (skid_vld_ff) begin
            head_in     = skid_ff;
            skid_vld_in = 1'b0;
         end else begin
            head_vld_in = 1'b0;
         end
      end
      if (frame_push) begin
         if (!head_vld_in) begin
            head_in     = frame;
            head_vld_in = 1'b1;
         end else begin
            skid_in     = frame;
            skid_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         head_vld_ff <= head_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign full                = skid_vld_ff;
   assign rsp_valid           = head_vld_ff;
   assign rsp_data_byte       = head_ff.data_byte;
   assign rsp_seg_low_nibble  = SEG_TABLE[head_ff.data_byte[3:0]];
   assign rsp_seg_high_nibble = SEG_TABLE[head_ff.data_byte[7:4]];
   assign rsp_start_error     = head_ff.start_err;
   assign rsp_parity_error    = head_ff.parity_err;
   assign rsp_stop_error      = head_ff.stop_err;

endmodule

>>> src/urx7_checker.sv
// Port-level checks of the UART receiver, bound to its top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module urx7_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall
);

   // A held result word stays offered until it is taken.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp word dropped while stalled")

   // The input side only stalls when a result word is waiting.
   `ASSERT_CLK(a_stall_needs_rsp, clock, reset, req_stall |-> rsp_valid, "req stalled with empty output")

   // A new result word always follows an accepted tick.
   `ASSERT_CLK(a_rsp_from_tick, clock, reset, $rose(rsp_valid) |-> $past(req_valid && !req_stall), "result without an accepted tick")

   // Reset empties the result queue.
   `ASSERT_CLK_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall, "queue not empty after reset")

endmodule

bind uart_rx_parity_seven_segment urx7_checker u_urx7_checker (.*);

>>> verif/uart_rx_parity_seven_segment_test.sv
// Self-checking testbench for the oversampled UART receiver with seven-segment output.
`timescale 1ns / 1ps

module uart_rx_parity_seven_segment_test;
   import urx7_pkg::*;

   localparam int DATA_BITS = DATA_BITS_DEF;
   localparam int unsigned CYCLE_LIMIT = 100000;
   localparam int unsigned HOLD_OFF_CYCLES = 400;

   // Indexes that map to no register, and the parity code with no meaning.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;
   localparam logic [MODE_W-1:0] PAR_RSVD = 2'd3;

   typedef struct {
      logic [BYTE_W-1:0] data_byte;
      logic [SEG_W-1:0]  seg_low;
      logic [SEG_W-1:0]  seg_high;
      logic              start_err;
      logic              parity_err;
      logic              stop_err;
   } rx_frame_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_rx_line = 1'b1;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [BYTE_W-1:0]    rsp_data_byte;
   logic [SEG_W-1:0]     rsp_seg_low_nibble;
   logic [SEG_W-1:0]     rsp_seg_high_nibble;
   logic                 rsp_start_error;
   logic                 rsp_parity_error;
   logic                 rsp_stop_error;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TICK_W-1:0]    csr_wdata = '0;

   logic         line_ticks[$];
   rx_frame_type expected_frames[$];
   logic         req_taken = 1'b0;
   int unsigned  error_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  frame_ticks = 0;
   int unsigned  idle_pct = 0;
   int unsigned  stall_pct = 0;
   bit           hold_go = 1'b0;
   bit           hold_done = 1'b0;
   int unsigned  hold_left = 0;

   // Receiver state as the block should hold it.
   logic [TICK_W-1:0] cfg_ticks = TICKS_PER_BIT_RST;
   logic [MODE_W-1:0] cfg_parity = PARITY_MODE_RST;
   rx_phase_type      rx_state = PH_IDLE;
   logic [TICK_W-1:0] tick_count = '0;
   logic [3:0]        bit_count = '0;
   logic [BYTE_W-1:0] shift_byte = '0;
   logic              parity_sum = 1'b0;
   logic              start_bad = 1'b0;
   logic              parity_bad = 1'b0;

   uart_rx_parity_seven_segment dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_line         (req_rx_line),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_seg_low_nibble  (rsp_seg_low_nibble),
      .rsp_seg_high_nibble (rsp_seg_high_nibble),
      .rsp_start_error     (rsp_start_error),
      .rsp_parity_error    (rsp_parity_error),
      .rsp_stop_error      (rsp_stop_error),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [SEG_W-1:0] hex_segments(input logic [3:0] digit);
      case (digit)
         4'h0: return 7'h01;
         4'h1: return 7'h4f;
         4'h2: return 7'h12;
         4'h3: return 7'h06;
         4'h4: return 7'h4c;
         4'h5: return 7'h24;
         4'h6: return 7'h20;
         4'h7: return 7'h0f;
         4'h8: return 7'h00;
         4'h9: return 7'h04;
         4'ha: return 7'h08;
         4'hb: return 7'h60;
         4'hc: return 7'h31;
         4'hd: return 7'h42;
         4'he: return 7'h30;
         default: return 7'h38;
      endcase
   endfunction

   // A zero-length wait counts as one tick; the compare is "at least" so a
   // shortened period never hangs the counter.
   function automatic bit period_elapsed(input logic [TICK_W-1:0] target);
      logic [TICK_W-1:0] goal;
      goal = (target == '0) ? 16'd1 : target;
      tick_count = tick_count + 1'b1;
      if (tick_count >= goal) begin
         tick_count = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic receive_tick(input logic line);
      rx_frame_type frame;
      logic         parity_on;
      parity_on = (cfg_parity == PAR_EVEN) || (cfg_parity == PAR_ODD);
      case (rx_state)
         PH_IDLE: begin
            if (!line) begin
               rx_state = PH_START;
               tick_count = '0;
               bit_count = '0;
               shift_byte = '0;
               parity_sum = 1'b0;
               start_bad = 1'b0;
               parity_bad = 1'b0;
            end
         end
         PH_START: begin
            if (period_elapsed(cfg_ticks >> 1)) begin
               start_bad = line;
               rx_state = PH_DATA;
            end
         end
         PH_DATA: begin
            if (period_elapsed(cfg_ticks)) begin
               if (bit_count < 4'd8) begin
                  shift_byte[bit_count[2:0]] = line;
               end
               parity_sum = parity_sum ^ line;
               bit_count = bit_count + 1'b1;
               if (bit_count >= DATA_BITS) begin
                  rx_state = parity_on ? PH_PARITY : PH_STOP;
               end
            end
         end
         PH_PARITY: begin
            if (period_elapsed(cfg_ticks)) begin
               if (cfg_parity == PAR_EVEN) begin
                  parity_bad = (line != parity_sum);
               end else if (cfg_parity == PAR_ODD) begin
                  parity_bad = (line == parity_sum);
               end else begin
                  parity_bad = 1'b0;
               end
               rx_state = PH_STOP;
            end
         end
         PH_STOP: begin
            if (period_elapsed(cfg_ticks)) begin
               frame.data_byte = shift_byte;
               frame.seg_low = hex_segments(shift_byte[3:0]);
               frame.seg_high = hex_segments(shift_byte[7:4]);
               frame.start_err = start_bad;
               frame.parity_err = parity_bad;
               frame.stop_err = !line;
               expected_frames.push_back(frame);
               rx_state = PH_IDLE;
               tick_count = '0;
            end
         end
         default: begin
            rx_state = PH_IDLE;
            tick_count = '0;
         end
      endcase
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Monitor and prediction share the rising edge; a result word is registered
   // in the result queue, so it only reaches the monitor after its tick.
   always @(posedge clock) begin
      rx_frame_type want;
      cycle_count++;
      req_taken <= req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               $display("%0t: unexpected result word, expected none, actual byte %0h",
                        $time, rsp_data_byte);
               error_count++;
            end else begin
               want = expected_frames.pop_front();
               check_field("data_byte", want.data_byte, rsp_data_byte);
               check_field("seg_low_nibble", want.seg_low, rsp_seg_low_nibble);
               check_field("seg_high_nibble", want.seg_high, rsp_seg_high_nibble);
               check_field("start_error", want.start_err, rsp_start_error);
               check_field("parity_error", want.parity_err, rsp_parity_error);
               check_field("stop_error", want.stop_err, rsp_stop_error);
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TICKS_PER_BIT) begin
               cfg_ticks = csr_wdata;
            end else if (csr_index == CSR_PARITY_MODE) begin
               cfg_parity = csr_wdata[MODE_W-1:0];
            end
         end
         if (req_valid && !req_stall) begin
            receive_tick(req_rx_line);
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (line_ticks.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_valid <= 1'b1;
            req_rx_line <= line_ticks.pop_front();
         end else begin
            req_valid <= 1'b0;
            req_rx_line <= 1'($urandom_range(1));
         end
      end
   end

   always @(negedge clock) begin
      if (hold_go && !hold_done) begin
         hold_left = HOLD_OFF_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TICK_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic push_level(input logic level, input int unsigned count);
      repeat (count) line_ticks.push_back(level);
      frame_ticks += count;
   endtask

   // Each bit is held for one period from the detecting tick, so samples land
   // mid-bit; with a period of one tick the start bit needs two ticks.
   task automatic push_frame(input logic [BYTE_W-1:0] value, input int unsigned ticks,
                             input logic [MODE_W-1:0] mode, input bit bad_start,
                             input bit bad_parity, input bit bad_stop,
                             input int unsigned gap);
      int unsigned hold;
      int unsigned start_len;
      hold = (ticks == 0) ? 1 : ticks;
      start_len = (ticks <= 1) ? 2 : ticks;
      if (bad_start) begin
         push_level(1'b0, 1);
         push_level(1'b1, start_len - 1);
      end else begin
         push_level(1'b0, start_len);
      end
      for (int i = 0; i < DATA_BITS; i++) begin
         push_level(value[i], hold);
      end
      if (mode == PAR_EVEN || mode == PAR_ODD) begin
         push_level((^value) ^ (mode == PAR_ODD) ^ bad_parity, hold);
      end
      push_level(!bad_stop, hold);
      push_level(1'b1, gap);
   endtask

   task automatic drain(input int unsigned settle);
      while (line_ticks.size() != 0 || req_valid) @(posedge clock);
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // A frame left open by broken input is closed with a high line, so the
   // block is idle before the next register write.
   task automatic finish_segment();
      drain(2);
      while (rx_state != PH_IDLE) begin
         push_level(1'b1, (cfg_ticks == '0) ? 1 : int'(cfg_ticks));
         drain(2);
      end
      drain(8);
   endtask

   task automatic random_segment(input int unsigned target_ticks);
      int unsigned ticks;
      int unsigned sel;
      int unsigned frames;
      int unsigned hold;
      logic [MODE_W-1:0] mode;
      logic [TICK_W-1:0] mode_word;
      sel = $urandom_range(99);
      if (sel < 10) begin
         ticks = $urandom_range(1);
      end else if (sel < 80) begin
         ticks = $urandom_range(2, 6);
      end else begin
         ticks = $urandom_range(7, 16);
      end
      mode = MODE_W'($urandom_range(3));
      mode_word = TICK_W'($urandom_range(65535));
      mode_word[MODE_W-1:0] = mode;
      write_reg(CSR_TICKS_PER_BIT, TICK_W'(ticks));
      write_reg(CSR_PARITY_MODE, mode_word);
      if ($urandom_range(3) == 0) begin
         write_reg($urandom_range(1) ? CSR_SPARE_2 : CSR_SPARE_3,
                   TICK_W'($urandom_range(65535)));
      end
      hold = (ticks == 0) ? 1 : ticks;
      frames = 0;
      frame_ticks = 0;
      while (frame_ticks < target_ticks || frames < 2) begin
         sel = $urandom_range(99);
         if (sel < 80) begin
            push_frame(BYTE_W'($urandom_range(255)), ticks, mode,
                       $urandom_range(99) < 10, $urandom_range(99) < 15,
                       $urandom_range(99) < 10, $urandom_range(99) < 70 ? 0 : $urandom_range(1, 6));
            frames++;
         end else begin
            repeat ($urandom_range(1, 3 * hold)) push_level(1'($urandom_range(1)), 1);
         end
      end
      finish_segment();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Even parity out of reset, with a short bit period written first.
      idle_pct = 0;
      stall_pct = 0;
      write_reg(CSR_TICKS_PER_BIT, 16'd4);
      push_frame(8'ha5, 4, PARITY_MODE_RST, 1'b0, 1'b0, 1'b0, 4);
      finish_segment();

      // One-tick bits, frames back to back, each error flag on its own.
      write_reg(CSR_TICKS_PER_BIT, 16'd1);
      write_reg(CSR_PARITY_MODE, {14'd0, PAR_EVEN});
      push_frame(8'h00, 1, PAR_EVEN, 1'b0, 1'b0, 1'b0, 0);
      push_frame(8'hff, 1, PAR_EVEN, 1'b0, 1'b1, 1'b0, 0);
      push_frame(8'h5a, 1, PAR_EVEN, 1'b1, 1'b0, 1'b0, 1);
      push_frame(8'h3c, 1, PAR_EVEN, 1'b0, 1'b0, 1'b1, 3);
      finish_segment();

      // A zero period behaves as one tick.
      write_reg(CSR_TICKS_PER_BIT, 16'd0);
      write_reg(CSR_PARITY_MODE, {14'd0, PAR_ODD});
      push_frame(8'hc3, 0, PAR_ODD, 1'b0, 1'b0, 1'b0, 1);
      push_frame(8'h96, 0, PAR_ODD, 1'b0, 1'b1, 1'b0, 1);
      finish_segment();

      // The reserved parity code has no parity bit; spare indexes change nothing.
      write_reg(CSR_TICKS_PER_BIT, 16'd2);
      write_reg(CSR_PARITY_MODE, {14'd0, PAR_RSVD});
      write_reg(CSR_SPARE_2, 16'hffff);
      write_reg(CSR_SPARE_3, 16'h0000);
      push_frame(8'h81, 2, PAR_RSVD, 1'b0, 1'b0, 1'b0, 2);
      push_frame(8'h7e, 2, PAR_RSVD, 1'b1, 1'b0, 1'b1, 2);
      finish_segment();

      // A longer odd bit period with no parity bit.
      write_reg(CSR_TICKS_PER_BIT, 16'd13);
      write_reg(CSR_PARITY_MODE, {14'd0, PAR_NONE});
      push_frame(8'h69, 13, PAR_NONE, 1'b0, 1'b0, 1'b0, 2);
      finish_segment();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 49;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 49;
            end
            default: begin
               idle_pct = 28;
               stall_pct = 28;
            end
         endcase
         repeat (2) random_segment(40);
         if (phase == 0) begin
            // Short frames pile up behind a long receiver hold-off until the
            // result queue fills and the input word stalls.
            write_reg(CSR_TICKS_PER_BIT, 16'd1);
            write_reg(CSR_PARITY_MODE, {14'd0, PAR_NONE});
            hold_go = 1'b1;
            repeat (24) push_frame(BYTE_W'($urandom_range(255)), 1, PAR_NONE,
                                   1'b0, 1'b0, 1'b0, 0);
            finish_segment();
         end
      end

      drain(20);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> uart_rx_parity_seven_segment.f
+incdir+src
src/urx7_pkg.sv
src/urx7_csr.sv
src/urx7_fsm.sv
src/urx7_out.sv
src/uart_rx_parity_seven_segment.sv
src/urx7_checker.sv
verif/uart_rx_parity_seven_segment_test.sv
